// ----- rtl/tsq_pkg.sv -----
// ----------------------------------------------------------------------------
// tsq_pkg: touch sample qualifier shared definitions
// Types, register indexes, command codes and constants used by the qualifier
// modules and interfaces.
// ----------------------------------------------------------------------------
package tsq_pkg;

   // Field widths
   localparam int unsigned COORD_W    = 16;
   localparam int unsigned STATUS_W   = 9;
   localparam int unsigned JITTER_W   = 10;
   localparam int unsigned TICKS_W    = 3;
   localparam int unsigned PRESSURE_W = 8;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // Coordinates on this value (or zero) are treated as panel edge hits
   localparam logic [COORD_W-1:0] COORD_EDGE = 16'd1024;

   // Command codes
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_INVERT_AXES      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_X_LIMIT          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_Y_LIMIT          = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_JITTER_THRESHOLD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PENUP_TICKS      = 3'd4;

   // Register reset values
   localparam logic [COORD_W-1:0]  X_LIMIT_RESET     = 16'd1024;
   localparam logic [COORD_W-1:0]  Y_LIMIT_RESET     = 16'd1024;
   localparam logic [JITTER_W-1:0] JITTER_RESET      = 10'd4;
   localparam logic [TICKS_W-1:0]  PENUP_TICKS_RESET = 3'd3;

   // Status word layout: bits 8:6 operation count, bits 5:1 pending samples
   localparam int unsigned OPS_LSB  = 6;
   localparam int unsigned OPS_MSB  = 8;
   localparam int unsigned PEND_LSB = 1;
   localparam int unsigned PEND_MSB = 5;
   localparam logic [OPS_MSB-OPS_LSB:0] OPS_COMPLETE = 3'd2;

   // Squared Y step above 60 flags a fast move; 7*7 = 49 and 8*8 = 64, so
   // the test reduces to a step larger than 7.
   localparam logic [COORD_W-1:0] FAST_STEP_MAX = 16'd7;

   localparam logic [PRESSURE_W-1:0] PRESSURE_TOUCH = 8'd255;
   localparam logic [TICKS_W-1:0]    IDLE_MAX       = 3'd7;

   typedef struct packed {
      logic                invert_axes;
      logic [COORD_W-1:0]  x_limit;
      logic [COORD_W-1:0]  y_limit;
      logic [JITTER_W-1:0] jitter_threshold;
      logic [TICKS_W-1:0]  penup_ticks;
   } cfg_type;

   typedef struct packed {
      logic                command;
      logic [STATUS_W-1:0] status_word;
      logic                data_ready;
      logic [COORD_W-1:0]  sample_x;
      logic [COORD_W-1:0]  sample_y;
   } item_type;

   typedef struct packed {
      logic [COORD_W-1:0] prev_x;
      logic [COORD_W-1:0] prev_y;
      logic               first_point;
      logic [TICKS_W-1:0] idle_count;
      logic               timer_armed;
   } state_type;

   typedef struct packed {
      logic                  pen_down;
      logic [COORD_W-1:0]    pos_x;
      logic [COORD_W-1:0]    pos_y;
      logic [PRESSURE_W-1:0] pressure;
      logic                  fast_move;
   } result_type;

endpackage

// ----- rtl/tsq_req_if.sv -----
// ----------------------------------------------------------------------------
// tsq_req_if: sample/tick request channel
// Valid/ready channel carrying one sample event or timer tick per transfer.
// ----------------------------------------------------------------------------
interface tsq_req_if
   import tsq_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                command;
   logic [STATUS_W-1:0] status_word;
   logic                data_ready;
   logic [COORD_W-1:0]  sample_x;
   logic [COORD_W-1:0]  sample_y;

   modport source (
      output valid, command, status_word, data_ready, sample_x, sample_y,
      input  ready
   );

   modport sink (
      input  valid, command, status_word, data_ready, sample_x, sample_y,
      output ready
   );
endinterface

// ----- rtl/tsq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// tsq_rsp_if: touch report channel
// Valid/ready channel carrying one position or pen-up report per transfer.
// ----------------------------------------------------------------------------
interface tsq_rsp_if
   import tsq_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic                  pen_down;
   logic [COORD_W-1:0]    pos_x;
   logic [COORD_W-1:0]    pos_y;
   logic [PRESSURE_W-1:0] pressure;
   logic                  fast_move;

   modport source (
      output valid, pen_down, pos_x, pos_y, pressure, fast_move,
      input  ready
   );

   modport sink (
      input  valid, pen_down, pos_x, pos_y, pressure, fast_move,
      output ready
   );
endinterface

// ----- rtl/tsq_csr.sv -----
// ----------------------------------------------------------------------------
// tsq_csr: configuration registers
// Write-only register bank holding inversion, limits, jitter and pen-up count.
// ----------------------------------------------------------------------------
module tsq_csr
   import tsq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; unknown indexes leave everything alone
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_INVERT_AXES:      cfg_in.invert_axes      = csr_wdata[0];
            REG_X_LIMIT:          cfg_in.x_limit          = csr_wdata[COORD_W-1:0];
            REG_Y_LIMIT:          cfg_in.y_limit          = csr_wdata[COORD_W-1:0];
            REG_JITTER_THRESHOLD: cfg_in.jitter_threshold = csr_wdata[JITTER_W-1:0];
            REG_PENUP_TICKS:      cfg_in.penup_ticks      = csr_wdata[TICKS_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.invert_axes      <= 1'b0;
         cfg_ff.x_limit          <= X_LIMIT_RESET;
         cfg_ff.y_limit          <= Y_LIMIT_RESET;
         cfg_ff.jitter_threshold <= JITTER_RESET;
         cfg_ff.penup_ticks      <= PENUP_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/tsq_eval.sv -----
// ----------------------------------------------------------------------------
// tsq_eval: sample qualification and report decision
// Combinational step: from one staged item, the configuration and the touch
// state, computes the next state and the report, if any.
// ----------------------------------------------------------------------------
module tsq_eval
   import tsq_pkg::*;
(
   input  item_type   item,
   input  cfg_type    cfg,
   input  state_type  cur,
   output state_type  nxt,
   output logic       emit,
   output result_type res
);

   logic [OPS_MSB-OPS_LSB:0]   ops;
   logic [PEND_MSB-PEND_LSB:0] pend;
   logic                       sample_ok;
   logic [COORD_W-1:0]         lx;
   logic [COORD_W-1:0]         ly;
   logic                       on_edge;
   logic [COORD_W-1:0]         dx;
   logic [COORD_W-1:0]         dy;
   logic [COORD_W-1:0]         thr;
   logic                       moved;

   assign ops  = item.status_word[OPS_MSB:OPS_LSB];
   assign pend = item.status_word[PEND_MSB:PEND_LSB];
   assign sample_ok = item.data_ready && (ops == OPS_COMPLETE) && (pend == '0);

   // Optional mirroring, clamped at zero
   always_comb begin
      if (cfg.invert_axes) begin
         lx = (cfg.x_limit > item.sample_x) ? cfg.x_limit - item.sample_x : '0;
         ly = (cfg.y_limit > item.sample_y) ? cfg.y_limit - item.sample_y : '0;
      end else begin
         lx = item.sample_x;
         ly = item.sample_y;
      end
   end

   assign on_edge = (lx == '0) || (lx == COORD_EDGE) || (ly == '0) || (ly == COORD_EDGE);

   // Movement against the last reported point
   assign dx    = (cur.prev_x > lx) ? cur.prev_x - lx : lx - cur.prev_x;
   assign dy    = (cur.prev_y > ly) ? cur.prev_y - ly : ly - cur.prev_y;
   assign thr   = {{(COORD_W-JITTER_W){1'b0}}, cfg.jitter_threshold};
   assign moved = (dx > thr) || (dy > thr);

   // Decision
   always_comb begin
      nxt  = cur;
      emit = 1'b0;
      res  = '0;
      if (item.command == CMD_TICK) begin
         if (cur.timer_armed) begin
            if (cur.idle_count >= cfg.penup_ticks) begin
               // pen-up report: all fields zero
               emit            = 1'b1;
               nxt.first_point = 1'b1;
               nxt.timer_armed = 1'b0;
            end
            if (cur.idle_count != IDLE_MAX) begin
               nxt.idle_count = cur.idle_count + 1'b1;
            end
         end
      end else begin
         nxt.idle_count = '0;
         if (sample_ok) begin
            nxt.timer_armed = 1'b1;
            if (!on_edge && (cur.first_point || moved)) begin
               emit            = 1'b1;
               nxt.first_point = 1'b0;
               nxt.prev_x      = lx;
               nxt.prev_y      = ly;
               res.pen_down    = 1'b1;
               res.pos_x       = lx;
               res.pos_y       = ly;
               res.pressure    = PRESSURE_TOUCH;
               res.fast_move   = !cur.first_point && (dy > FAST_STEP_MAX);
            end
         end
      end
   end

endmodule

// ----- rtl/touch_sample_qualifier.sv -----
// ----------------------------------------------------------------------------
// touch_sample_qualifier: touch sample qualifier top level
// Input register, qualification step, touch state and report register.
// ----------------------------------------------------------------------------
//
//   channel   direction  transfer / payload
//   req       in         valid & ready; command, status_word, data_ready,
//                        sample_x, sample_y
//   rsp       out        valid & ready; pen_down, pos_x, pos_y, pressure,
//                        fast_move
//   csr       in         csr_we; csr_index, csr_wdata (write only)
//
// One item per cycle sustained while rsp takes reports. An accepted item sits in
// the input register, is evaluated there against the touch state, and its
// report, if any, is captured in the report register and presented on rsp.
// Reset (synchronous) restores register defaults and clears state.
// A report held by rsp stalls the input register; req ready then drops.
// ----------------------------------------------------------------------------
module touch_sample_qualifier
   import tsq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   tsq_req_if.sink               req,
   tsq_rsp_if.source             rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   item_type   s1_item_ff;
   logic       s1_valid_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type out_ff;
   logic       out_valid_ff;
   logic       emit;
   result_type res;
   logic       out_free;
   logic       s1_adv;
   logic       req_xfer;

   tsq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tsq_eval u_eval (
      .item (s1_item_ff),
      .cfg  (cfg),
      .cur  (state_ff),
      .nxt  (state_in),
      .emit (emit),
      .res  (res)
   );

   // Handshake control
   assign out_free  = !out_valid_ff || rsp.ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req.ready = !s1_valid_ff || s1_adv;
   assign req_xfer  = req.valid && req.ready;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
      if (req_xfer) begin
         s1_item_ff.command     <= req.command;
         s1_item_ff.status_word <= req.status_word;
         s1_item_ff.data_ready  <= req.data_ready;
         s1_item_ff.sample_x    <= req.sample_x;
         s1_item_ff.sample_y    <= req.sample_y;
      end
   end

   // Touch state, updated once per evaluated item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.prev_x      <= '0;
         state_ff.prev_y      <= '0;
         state_ff.first_point <= 1'b1;
         state_ff.idle_count  <= '0;
         state_ff.timer_armed <= 1'b0;
      end else if (s1_adv) begin
         state_ff <= state_in;
      end
   end

   // Report register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_adv && emit;
      end
      if (s1_adv && emit) begin
         out_ff <= res;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.pen_down  = out_ff.pen_down;
   assign rsp.pos_x     = out_ff.pos_x;
   assign rsp.pos_y     = out_ff.pos_y;
   assign rsp.pressure  = out_ff.pressure;
   assign rsp.fast_move = out_ff.fast_move;

   // A staged item is never dropped while the report side stalls
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff)
      else $error("staged item lost during stall");

   // A sample event always leaves the idle count cleared
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_item_ff.command == CMD_SAMPLE |=> state_ff.idle_count == '0)
      else $error("idle count not cleared by sample");

   // Issuing pen-up disarms the timer and marks the next point as first
   a_penup_state: assert property (@(posedge clock) disable iff (reset)
      s1_adv && emit && !res.pen_down |=> state_ff.first_point && !state_ff.timer_armed)
      else $error("pen-up did not reset touch state");

   // Pen-up reports carry zero payload
   a_penup_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.pen_down |->
         rsp.pos_x == '0 && rsp.pos_y == '0 && rsp.pressure == '0 && !rsp.fast_move)
      else $error("pen-up report with nonzero payload");

   // Position reports never sit on the zero edge and carry full pressure
   a_touch_report: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.pen_down |->
         rsp.pos_x != '0 && rsp.pos_y != '0 && rsp.pressure == PRESSURE_TOUCH)
      else $error("malformed position report");

endmodule
